// File: rtl/tdr_pkg.sv
`default_nettype none
package tdr_pkg;

   localparam int unsigned MAX_DRAWS = 255;

   localparam logic [31:0] WORD_A_RESET = 32'd390451501;
   localparam logic [31:0] WORD_B_RESET = 32'd613566701;
   localparam logic [31:0] WORD_C_RESET = 32'd858993401;

   localparam logic [31:0] SEED_A_LIMIT = 32'h0008_0000;
   localparam logic [31:0] SEED_B_LIMIT = 32'h0200_0000;
   localparam logic [31:0] SEED_C_LIMIT = 32'h0000_0800;

   localparam logic [1:0] CSR_SEED_FIRST  = 2'd0;
   localparam logic [1:0] CSR_SEED_SECOND = 2'd1;
   localparam logic [1:0] CSR_SEED_THIRD  = 2'd2;

   localparam logic REQ_RESEED = 1'b0;
   localparam logic REQ_DRAW   = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_GEN,
      ST_WAIT,
      ST_DONE
   } state_type;

   // Generator control from the sequencer.
   typedef struct packed {
      logic advance;
      logic reseed;
   } gen_ctrl_type;

endpackage
`default_nettype wire

// File: rtl/tdr_taus.sv
`default_nettype none
module tdr_taus
   import tdr_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire gen_ctrl_type ctrl,
   input  wire logic [31:0]  seed_a,
   input  wire logic [31:0]  seed_b,
   input  wire logic [31:0]  seed_c,
   output logic [31:0]       rnd
);

   logic [31:0] word_a_ff, word_b_ff, word_c_ff;
   logic [31:0] word_a_in, word_b_in, word_c_in;
   logic [31:0] src_a, src_b, src_c;

   // A reseed replaces each word whose seed passes its threshold.
   always_comb begin
      src_a = word_a_ff;
      src_b = word_b_ff;
      src_c = word_c_ff;
      if (ctrl.reseed) begin
         if (seed_a > SEED_A_LIMIT) src_a = seed_a;
         if (seed_b > SEED_B_LIMIT) src_b = seed_b;
         if (seed_c > SEED_C_LIMIT) src_c = seed_c;
      end
   end

   // One step of the three Tausworthe recurrences.
   always_comb begin
      word_a_in = ((src_a & 32'hFFFF_FFFE) << 12) ^ (((src_a << 13) ^ src_a) >> 19);
      word_b_in = ((src_b & 32'hFFFF_FFF8) << 4)  ^ (((src_b << 2) ^ src_b) >> 25);
      word_c_in = ((src_c & 32'hFFFF_FFF0) << 17) ^ (((src_c << 3) ^ src_c) >> 11);
      rnd = word_a_in ^ word_b_in ^ word_c_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_a_ff <= WORD_A_RESET;
         word_b_ff <= WORD_B_RESET;
         word_c_ff <= WORD_C_RESET;
      end else if (ctrl.advance) begin
         word_a_ff <= word_a_in;
         word_b_ff <= word_b_in;
         word_c_ff <= word_c_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/tdr_mod.sv
`default_nettype none
module tdr_mod
   import tdr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] dividend,
   input  wire logic [32:0] divisor,
   output logic             done,
   output logic [32:0]      remainder
);

   logic [31:0] quot_ff, quot_in;
   logic [32:0] rem_ff, rem_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [33:0] trial;

   // Restoring remainder, one dividend bit per cycle.
   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quot_ff[31]};
      if (start) begin
         quot_in = dividend;
         rem_in  = '0;
         cnt_in  = 6'd32;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in = 33'(trial - {1'b0, divisor});
         end else begin
            rem_in = trial[32:0];
         end
         quot_in = {quot_ff[30:0], 1'b0};
         cnt_in  = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule
`default_nettype wire

// File: rtl/tausworthe_ranged_draw.sv
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  req_type, req_range_low, req_range_high,
//                                           req_draw_count
// rsp       out        rsp_valid/rsp_stall  rsp_draw_sum, rsp_range_error
// csr       in         csr_write            csr_index, csr_data
//
// A reseed, an error or a zero count shows its result in the cycle after the transfer.
// Each draw attempt is one generator step and one run of the serial
// remainder unit; rejected attempts repeat it.
// Synchronous active-high reset restores the generator words and seeds.
// The block takes one item at a time and holds its result until transferred.
`default_nettype none
module tausworthe_ranged_draw
   import tdr_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_type,
   input  wire logic signed [31:0] req_range_low,
   input  wire logic signed [31:0] req_range_high,
   input  wire logic [7:0]         req_draw_count,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [39:0]      rsp_draw_sum,
   output logic                    rsp_range_error,
   input  wire logic               csr_write,
   input  wire logic [1:0]         csr_index,
   input  wire logic [31:0]        csr_data
);

   state_type   state_ff, state_in;
   logic [31:0] seed_a_ff, seed_b_ff, seed_c_ff;
   logic [32:0] mod_ff, mod_in;
   logic [31:0] min_ff, min_in;
   logic signed [31:0] off_ff, off_in;
   logic        neg_ff, neg_in;
   logic [7:0]  cnt_ff, cnt_in;
   logic signed [39:0] sum_ff, sum_in;
   logic        err_ff, err_in;
   gen_ctrl_type gen_ctrl;
   logic [31:0] rnd;
   logic        mod_start, mod_done;
   logic [32:0] rem;
   logic        accept;
   logic [33:0] lo_x, hi_x;
   logic signed [39:0] draw_val;

   // Seed registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_a_ff <= '0;
         seed_b_ff <= '0;
         seed_c_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_SEED_FIRST:  seed_a_ff <= csr_data;
            CSR_SEED_SECOND: seed_b_ff <= csr_data;
            CSR_SEED_THIRD:  seed_c_ff <= csr_data;
            default: ;
         endcase
      end
   end

   tdr_taus u_taus (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (gen_ctrl),
      .seed_a (seed_a_ff),
      .seed_b (seed_b_ff),
      .seed_c (seed_c_ff),
      .rnd    (rnd)
   );

   tdr_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (rnd),
      .divisor   (mod_ff),
      .done      (mod_done),
      .remainder (rem)
   );

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign lo_x      = {{2{req_range_low[31]}}, req_range_low};
   assign hi_x      = {{2{req_range_high[31]}}, req_range_high};

   // Value of a finished draw: negated span, shifted span or plain.
   always_comb begin
      if (neg_ff) begin
         draw_val = -$signed({7'b0, rem});
      end else begin
         draw_val = $signed({7'b0, rem}) + 40'(off_ff);
      end
   end

   // Sequencer.
   always_comb begin
      state_in  = state_ff;
      mod_in    = mod_ff;
      min_in    = min_ff;
      off_in    = off_ff;
      neg_in    = neg_ff;
      cnt_in    = cnt_ff;
      sum_in    = sum_ff;
      err_in    = err_ff;
      gen_ctrl  = '0;
      mod_start = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               sum_in   = '0;
               err_in   = 1'b0;
               state_in = ST_DONE;
               cnt_in   = (32'(req_draw_count) > MAX_DRAWS) ? 8'(MAX_DRAWS) : req_draw_count;
               if (req_type == REQ_RESEED) begin
                  gen_ctrl.reseed  = 1'b1;
                  gen_ctrl.advance = 1'b1;
               end else if (req_range_low > req_range_high) begin
                  err_in = 1'b1;
               end else if (req_draw_count != 8'd0) begin
                  state_in = ST_GEN;
                  if (!req_range_low[31]) begin
                     mod_in = 33'(hi_x + 34'd1);
                     min_in = req_range_low;
                     off_in = '0;
                     neg_in = 1'b0;
                  end else if (!req_range_high[31]) begin
                     mod_in = 33'(hi_x - lo_x + 34'd1);
                     min_in = '0;
                     off_in = req_range_low;
                     neg_in = 1'b0;
                  end else begin
                     mod_in = 33'(34'd1 - lo_x);
                     min_in = 32'(34'd0 - hi_x);
                     off_in = '0;
                     neg_in = 1'b1;
                  end
               end
            end
         end
         ST_GEN: begin
            gen_ctrl.advance = 1'b1;
            mod_start        = 1'b1;
            state_in         = ST_WAIT;
         end
         ST_WAIT: begin
            if (mod_done) begin
               if (rem < {1'b0, min_ff}) begin
                  state_in = ST_GEN;
               end else begin
                  sum_in = sum_ff + draw_val;
                  cnt_in = cnt_ff - 8'd1;
                  state_in = (cnt_ff == 8'd1) ? ST_DONE : ST_GEN;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      mod_ff <= mod_in;
      min_ff <= min_in;
      off_ff <= off_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      sum_ff <= sum_in;
      err_ff <= err_in;
   end

   assign rsp_valid       = (state_ff == ST_DONE);
   assign rsp_draw_sum    = sum_ff;
   assign rsp_range_error = err_ff;

   // A transfer in always leaves the block busy in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> req_stall)
      else $error("input transfer did not make the block busy");

   // An error result carries a zero sum.
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_range_error) |-> (rsp_draw_sum == 40'sd0))
      else $error("error result with nonzero sum");

   // A reseed result is never an error.
   a_reseed_clean: assert property (@(posedge clock) disable iff (reset)
      (accept && req_type == REQ_RESEED) |=> (rsp_valid && !rsp_range_error))
      else $error("reseed did not finish cleanly");

endmodule
`default_nettype wire
